FILE: sv/pgp_pkg.sv
// Shared types, constants and address helpers for the grid projection stencil.
`default_nettype none
package pgp_pkg;

  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int COORD_W = 5;
  localparam int WORD_W  = 32;
  localparam int FGH_W   = 3 * WORD_W;
  localparam int DIFF_W  = WORD_W + 1;
  localparam int HALF_W  = 16;
  localparam int PROD_W  = DIFF_W + HALF_W + 1;
  localparam int ACC_W   = PROD_W + HALF_W + 2;
  localparam int RND_W   = ACC_W - HALF_W;
  localparam int VAL_W   = RND_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef logic [1:0]                op_t;
  typedef logic [1:0]                lane_t;
  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  localparam op_t OP_WR_VEL = 2'd0;
  localparam op_t OP_WR_P   = 2'd1;
  localparam op_t OP_RD_DIV = 2'd2;
  localparam op_t OP_RD_VEL = 2'd3;

  localparam cfg_idx_t CFG_INV_DX = 3'd0;
  localparam cfg_idx_t CFG_INV_DY = 3'd1;
  localparam cfg_idx_t CFG_INV_DZ = 3'd2;
  localparam cfg_idx_t CFG_DT_DX  = 3'd3;
  localparam cfg_idx_t CFG_DT_DY  = 3'd4;
  localparam cfg_idx_t CFG_DT_DZ  = 3'd5;

  localparam lane_t LANE_FIRST = 2'd0;
  localparam lane_t LANE_LAST  = 2'd2;

  localparam logic [WORD_W-1:0] COEF_RESET = 32'h0001_0000;
  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(32768);

  typedef struct packed {
    logic  valid;
    logic  first;
    logic  last;
    logic  sub;
    lane_t lane;
  } mac_ctl_t;

  typedef struct packed {
    logic              valid;
    lane_t             lane;
    logic              clip;
    logic [WORD_W-1:0] value;
  } mac_res_t;

  function automatic logic in_grid(coord_t x, coord_t y, coord_t z);
    return (32'(x) < GRID_X) && (32'(y) < GRID_Y) && (32'(z) < GRID_Z);
  endfunction

  function automatic coord_t wrap_dec(coord_t v, int unsigned grid);
    return (v == '0) ? COORD_W'(grid - 1) : v - 1'b1;
  endfunction

  function automatic coord_t wrap_inc(coord_t v, int unsigned grid);
    return ((32'(v) + 32'd1) >= grid) ? '0 : v + 1'b1;
  endfunction

  function automatic addr_t cell_addr(coord_t x, coord_t y, coord_t z);
    addr_t ax, ay, az;
    ax = ADDR_W'(x);
    ay = ADDR_W'(y);
    az = ADDR_W'(z);
    return (ax * ADDR_W'(GRID_Y) + ay) * ADDR_W'(GRID_Z) + az;
  endfunction

endpackage
`default_nettype wire

FILE: sv/pgp_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
`default_nettype none
module pgp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32768,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

FILE: sv/pgp_mac.sv
// Pipelined multiply-accumulate, rounding and saturation for stencil terms.
`default_nettype none
module pgp_mac (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pgp_pkg::mac_ctl_t     ctl,
  input  wire pgp_pkg::diff_t        d,
  input  wire logic [31:0]           coef,
  input  wire pgp_pkg::word_t        base,
  output pgp_pkg::mac_res_t          res
);
  import pgp_pkg::*;

  mac_ctl_t s1_ctl, s2_ctl, s3_ctl;
  word_t    s1_base, s2_base, s3_base;
  logic signed [PROD_W-1:0] p_hi, p_lo;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  hi_ext, lo_ext, term, rnd_sum;
  logic signed [RND_W-1:0]  rnd;
  logic signed [VAL_W-1:0]  val;
  logic                     clip;

  // coefficient split in two 16-bit halves keeps each multiplier near 33x17
  always_ff @(posedge clk) begin
    p_hi    <= d * $signed({1'b0, coef[WORD_W-1:HALF_W]});
    p_lo    <= d * $signed({1'b0, coef[HALF_W-1:0]});
    s1_base <= base;
  end

  always_comb begin
    hi_ext  = {{(ACC_W-PROD_W){p_hi[PROD_W-1]}}, p_hi};
    lo_ext  = {{(ACC_W-PROD_W){p_lo[PROD_W-1]}}, p_lo};
    term    = {hi_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}} + lo_ext;
    rnd_sum = acc + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid) begin
      acc <= (s1_ctl.first ? '0 : acc) + term;
    end
    s2_base <= s1_base;
    rnd     <= rnd_sum[ACC_W-1:HALF_W];
    s3_base <= s2_base;
  end

  always_comb begin
    if (s3_ctl.sub) begin
      val = {{(VAL_W-WORD_W){s3_base[WORD_W-1]}}, s3_base} - {rnd[RND_W-1], rnd};
    end else begin
      val = {rnd[RND_W-1], rnd};
    end
    clip = !((&val[VAL_W-1:WORD_W-1]) || !(|val[VAL_W-1:WORD_W-1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      s3_ctl    <= '0;
      res.valid <= 1'b0;
    end else begin
      s1_ctl    <= ctl;
      // only the last term of a sum leaves the accumulator
      s2_ctl    <= '{valid: s1_ctl.valid && s1_ctl.last, first: s1_ctl.first,
                     last: s1_ctl.last, sub: s1_ctl.sub, lane: s1_ctl.lane};
      s3_ctl    <= s2_ctl;
      res.valid <= s3_ctl.valid;
    end
    res.lane <= s3_ctl.lane;
    res.clip <= clip;
    if (clip) begin
      res.value <= val[VAL_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res.value <= val[WORD_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/periodic_grid_projection_stencil_unit.sv
// Top level: grid memories, read sequencer, coefficient registers, result register.
//
//   channel  handshake               payload
//   cfg      cfg_we                  cfg_index, cfg_data
//   in       in_valid / in_ready     operation, cell_x/y/z, f/g/h/p_value
//   out      out_valid / out_ready   divergence, u/v/w_new, saturated, out_of_range
//
// Writes are accepted in idle and can follow back to back.
// An in-range read passes from acceptance to out_valid through dual-port reads
// of the F/G/H and pressure memories in S_RD0 and S_RD1, three terms through
// the shared multiply-accumulate pipe, its four pipe stages and a result load.
// Reset clears control and loads coefficients with 1.0; memories are not cleared.
// A result held on out waits for out_ready; in_ready returns with it.
`default_nettype none
module periodic_grid_projection_stencil_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire pgp_pkg::cfg_idx_t cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pgp_pkg::op_t      operation,
  input  wire pgp_pkg::coord_t   cell_x,
  input  wire pgp_pkg::coord_t   cell_y,
  input  wire pgp_pkg::coord_t   cell_z,
  input  wire pgp_pkg::word_t    f_value,
  input  wire pgp_pkg::word_t    g_value,
  input  wire pgp_pkg::word_t    h_value,
  input  wire pgp_pkg::word_t    p_value,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pgp_pkg::word_t         divergence,
  output pgp_pkg::word_t         u_new,
  output pgp_pkg::word_t         v_new,
  output pgp_pkg::word_t         w_new,
  output logic                   saturated,
  output logic                   out_of_range
);
  import pgp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD0   = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_TERM  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]  state;
  op_t         op_q;
  coord_t      cx, cy, cz;
  logic        oor_q;
  lane_t       lane;
  logic [31:0] inv_c [3];
  logic [31:0] dt_c  [3];
  word_t       ctr_q [3];
  word_t       nb_q  [3];
  word_t       pn_q  [3];
  word_t       pctr_q;
  word_t       res_div, res_u, res_v, res_w;
  logic        clip_q;

  logic        in_acc, rd_op, in_ok, slot_free, is_div;
  logic        fgh_we, p_we;
  addr_t       waddr, fgh_ra, fgh_rb, p_ra, p_rb;
  logic [FGH_W-1:0]  fgh_a, fgh_b;
  logic [WORD_W-1:0] p_a, p_b;
  mac_ctl_t    mac_ctl;
  diff_t       mac_d;
  logic [31:0] mac_coef;
  word_t       mac_base;
  mac_res_t    mac_res;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign rd_op     = (operation == OP_RD_DIV) || (operation == OP_RD_VEL);
  assign in_ok     = in_grid(cell_x, cell_y, cell_z);
  assign slot_free = !out_valid || out_ready;
  assign is_div    = (op_q == OP_RD_DIV);

  // writes only land in idle, reads only in the read states: no same-cycle overlap
  assign waddr  = cell_addr(cell_x, cell_y, cell_z);
  assign fgh_we = in_acc && (operation == OP_WR_VEL) && in_ok;
  assign p_we   = in_acc && (operation == OP_WR_P) && in_ok;

  always_comb begin
    if (state == S_RD0) begin
      fgh_ra = cell_addr(cx, cy, cz);
      fgh_rb = cell_addr(wrap_dec(cx, GRID_X), cy, cz);
      p_ra   = cell_addr(cx, cy, cz);
      p_rb   = cell_addr(wrap_inc(cx, GRID_X), cy, cz);
    end else begin
      fgh_ra = cell_addr(cx, wrap_dec(cy, GRID_Y), cz);
      fgh_rb = cell_addr(cx, cy, wrap_dec(cz, GRID_Z));
      p_ra   = cell_addr(cx, wrap_inc(cy, GRID_Y), cz);
      p_rb   = cell_addr(cx, cy, wrap_inc(cz, GRID_Z));
    end
  end

  pgp_ram #(.WIDTH(FGH_W), .DEPTH(CELLS)) u_fgh_ram (
    .clk     (clk),
    .we      (fgh_we),
    .waddr   (waddr),
    .wdata   ({h_value, g_value, f_value}),
    .raddr_a (fgh_ra),
    .raddr_b (fgh_rb),
    .rdata_a (fgh_a),
    .rdata_b (fgh_b)
  );

  pgp_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_p_ram (
    .clk     (clk),
    .we      (p_we),
    .waddr   (waddr),
    .wdata   (p_value),
    .raddr_a (p_ra),
    .raddr_b (p_rb),
    .rdata_a (p_a),
    .rdata_b (p_b)
  );

  // one term per cycle; divergence sums three, velocity rounds each on its own
  always_comb begin
    mac_ctl.valid = (state == S_TERM);
    mac_ctl.first = !is_div || (lane == LANE_FIRST);
    mac_ctl.last  = !is_div || (lane == LANE_LAST);
    mac_ctl.sub   = !is_div;
    mac_ctl.lane  = lane;
    mac_base      = ctr_q[lane];
    if (is_div) begin
      mac_d    = {ctr_q[lane][WORD_W-1], ctr_q[lane]} - {nb_q[lane][WORD_W-1], nb_q[lane]};
      mac_coef = inv_c[lane];
    end else begin
      mac_d    = {pn_q[lane][WORD_W-1], pn_q[lane]} - {pctr_q[WORD_W-1], pctr_q};
      mac_coef = dt_c[lane];
    end
  end

  pgp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .d    (mac_d),
    .coef (mac_coef),
    .base (mac_base),
    .res  (mac_res)
  );

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        inv_c[i] <= COEF_RESET;
        dt_c[i]  <= COEF_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_DX: inv_c[0] <= cfg_data;
        CFG_INV_DY: inv_c[1] <= cfg_data;
        CFG_INV_DZ: inv_c[2] <= cfg_data;
        CFG_DT_DX:  dt_c[0]  <= cfg_data;
        CFG_DT_DY:  dt_c[1]  <= cfg_data;
        CFG_DT_DZ:  dt_c[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane  <= LANE_FIRST;
      oor_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && rd_op) begin
            oor_q <= !in_ok;
            state <= in_ok ? S_RD0 : S_DONE;
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin
          lane  <= LANE_FIRST;
          state <= S_TERM;
        end
        S_TERM: begin
          if (lane == LANE_LAST) begin
            state <= S_DRAIN;
          end else begin
            lane <= lane + 1'b1;
          end
        end
        S_DRAIN: begin
          if (mac_res.valid && (mac_res.lane == LANE_LAST)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item latch, memory data capture and result collection
  always_ff @(posedge clk) begin
    if (in_acc && rd_op) begin
      op_q    <= operation;
      cx      <= cell_x;
      cy      <= cell_y;
      cz      <= cell_z;
      res_div <= '0;
      res_u   <= '0;
      res_v   <= '0;
      res_w   <= '0;
      clip_q  <= 1'b0;
    end else if (mac_res.valid) begin
      clip_q <= clip_q | mac_res.clip;
      if (is_div) begin
        res_div <= mac_res.value;
      end else begin
        case (mac_res.lane)
          2'd0:    res_u <= mac_res.value;
          2'd1:    res_v <= mac_res.value;
          default: res_w <= mac_res.value;
        endcase
      end
    end
    if (state == S_RD1) begin
      ctr_q[0] <= fgh_a[WORD_W-1:0];
      ctr_q[1] <= fgh_a[2*WORD_W-1:WORD_W];
      ctr_q[2] <= fgh_a[FGH_W-1:2*WORD_W];
      nb_q[0]  <= fgh_b[WORD_W-1:0];
      pctr_q   <= p_a;
      pn_q[0]  <= p_b;
    end
    if ((state == S_TERM) && (lane == LANE_FIRST)) begin
      nb_q[1] <= fgh_a[2*WORD_W-1:WORD_W];
      nb_q[2] <= fgh_b[FGH_W-1:2*WORD_W];
      pn_q[1] <= p_a;
      pn_q[2] <= p_b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && slot_free) begin
      divergence   <= res_div;
      u_new        <= res_u;
      v_new        <= res_v;
      w_new        <= res_w;
      saturated    <= clip_q && !oor_q;
      out_of_range <= oor_q;
    end
  end

endmodule
`default_nettype wire

FILE: sv/pgp_checker.sv
// Port-level checks for the stencil unit and the bind that attaches them.
`default_nettype none
module pgp_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire pgp_pkg::op_t      operation,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire pgp_pkg::word_t    divergence,
  input wire pgp_pkg::word_t    u_new,
  input wire pgp_pkg::word_t    v_new,
  input wire pgp_pkg::word_t    w_new,
  input wire logic              saturated,
  input wire logic              out_of_range
);
  import pgp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(divergence) && $stable(u_new)
      && $stable(v_new) && $stable(w_new))
    else $error("result changed while stalled");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_RD_DIV || operation == OP_RD_VEL)
      |=> !in_ready)
    else $error("input taken while a read transaction is in progress");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid
      && (operation == OP_WR_VEL || operation == OP_WR_P) |=> !out_valid)
    else $error("write transaction produced a result");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> divergence == 0 && u_new == 0 && v_new == 0
      && w_new == 0 && !saturated)
    else $error("out-of-range result carries data");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (u_new != 0 || v_new != 0 || w_new != 0) |-> divergence == 0)
    else $error("divergence and velocity both nonzero");

endmodule

bind periodic_grid_projection_stencil_unit pgp_checker u_pgp_checker (.*);
`default_nettype wire
